// ===== hw/rtl/albr_pkg.sv =====
// ----------------------------------------------------------------------------
// albr_pkg
// Shared types and constants of the append-log block remapper: field widths,
// operation and status codes, register indexes and the front-to-back command.
// ----------------------------------------------------------------------------
package albr_pkg;

   localparam int SECTOR_W    = 32;
   localparam int MAP_ENTRIES = 4096;
   localparam int BLK_W       = $clog2(MAP_ENTRIES);
   localparam int MAP_W       = SECTOR_W + 1;   // valid bit + physical sector
   localparam int SPB_W       = 8;
   localparam int LBC_W       = 13;
   localparam int COUNT_W     = 16;
   localparam int OP_W        = 2;
   localparam int STATUS_W    = 3;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 32;
   localparam int BOUND_W     = SPB_W + LBC_W;
   localparam int DIV_CNT_W   = $clog2(BLK_W);
   // power of two, pointers wrap naturally
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   localparam logic [CSR_IDX_W-1:0] CSR_SECTORS_PER_BLOCK   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOGICAL_BLOCK_COUNT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PHYS_LIMIT          = 2'd2;

   localparam logic [SPB_W-1:0]    SPB_RESET   = 8'd8;
   localparam logic [LBC_W-1:0]    LBC_RESET   = 13'd4096;
   localparam logic [SECTOR_W-1:0] LIMIT_RESET = 32'hFFFF_FFFF;

   typedef enum logic [OP_W-1:0] {
      OP_READ  = 2'd0,
      OP_WRITE = 2'd1,
      OP_FLUSH = 2'd2,
      OP_OTHER = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_REMAPPED = 3'd0,
      ST_UNMAPPED = 3'd1,
      ST_INVALID  = 3'd2,
      ST_NOSPACE  = 3'd3,
      ST_FLUSH    = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      CMD_READ    = 2'd0,
      CMD_WRITE   = 2'd1,
      CMD_FLUSH   = 2'd2,
      CMD_INVALID = 2'd3
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type     kind;
      logic [BLK_W-1:0] blk;
   } cmd_type;

   typedef enum logic [2:0] {
      F_IDLE,
      F_MUL,
      F_RANGE,
      F_DIV,
      F_PUSH
   } front_state_type;

   typedef enum logic [2:0] {
      B_CLEAR,
      B_IDLE,
      B_READ,
      B_WRITE,
      B_OUT
   } back_state_type;

endpackage

// ===== hw/rtl/albr_ram.sv =====
// ----------------------------------------------------------------------------
// albr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module albr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== hw/rtl/albr_queue.sv =====
// ----------------------------------------------------------------------------
// albr_queue
// Short command queue between the request front end and the map back end.
// ----------------------------------------------------------------------------
module albr_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  albr_pkg::cmd_type push_cmd,
   output logic             push_ready,
   input  logic             pop,
   output logic             pop_valid,
   output albr_pkg::cmd_type pop_cmd
);

   albr_pkg::cmd_type             slot_ff [albr_pkg::QUEUE_DEPTH];
   logic [albr_pkg::QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [albr_pkg::QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [albr_pkg::QUEUE_AW:0]   count_ff, count_in;
   logic                          do_push, do_pop;

   assign push_ready = count_ff != (albr_pkg::QUEUE_AW+1)'(albr_pkg::QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_cmd    = slot_ff[rd_ptr_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (albr_pkg::QUEUE_AW+1)'(albr_pkg::QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count missed a push");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("empty queue with pointers apart");

endmodule

// ===== hw/rtl/albr_front.sv =====
// ----------------------------------------------------------------------------
// albr_front
// Request front end: takes a request, checks size, alignment and range, and
// finds the logical block with a bit-serial divide by the block size.
// ----------------------------------------------------------------------------
module albr_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               enable,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [albr_pkg::OP_W-1:0]          req_operation,
   input  logic [albr_pkg::SECTOR_W-1:0]      req_logical_sector,
   input  logic [albr_pkg::COUNT_W-1:0]       req_sector_count,
   input  logic [albr_pkg::SPB_W-1:0]         spb,
   input  logic [albr_pkg::LBC_W-1:0]         lbc,
   output logic                               cmd_valid,
   input  logic                               cmd_ready,
   output albr_pkg::cmd_type                  cmd
);

   albr_pkg::front_state_type        state_ff, state_in;
   albr_pkg::op_type                 op_ff, op_in;
   logic [albr_pkg::SECTOR_W-1:0]    lsec_ff, lsec_in;
   logic [albr_pkg::COUNT_W-1:0]     count_ff, count_in;
   logic [albr_pkg::BOUND_W-1:0]     bound_ff, bound_in;
   logic [albr_pkg::SPB_W-1:0]       rem_ff, rem_in;
   logic [albr_pkg::BLK_W-1:0]       low_ff, low_in;
   logic [albr_pkg::BLK_W-1:0]       quot_ff, quot_in;
   logic [albr_pkg::DIV_CNT_W-1:0]   cnt_ff, cnt_in;
   albr_pkg::cmd_type                cmd_ff, cmd_in;
   logic [albr_pkg::LBC_W-1:0]       lim;
   logic [albr_pkg::SPB_W:0]         trial;
   logic                             fits;
   logic [albr_pkg::SPB_W-1:0]       rem_next;
   logic [albr_pkg::BLK_W-1:0]       quot_next;
   logic                             accept;

   assign req_ready = enable && (state_ff == albr_pkg::F_IDLE);
   assign accept    = req_valid && req_ready;
   assign cmd_valid = state_ff == albr_pkg::F_PUSH;
   assign cmd       = cmd_ff;

   assign lim = (lbc > albr_pkg::LBC_W'(albr_pkg::MAP_ENTRIES)) ?
                albr_pkg::LBC_W'(albr_pkg::MAP_ENTRIES) : lbc;

   // one restoring-divide step; remainder stays below the block size
   assign trial     = {rem_ff, low_ff[albr_pkg::BLK_W-1]};
   assign fits      = trial >= {1'b0, spb};
   assign rem_next  = fits ? albr_pkg::SPB_W'(trial - {1'b0, spb})
                           : albr_pkg::SPB_W'(trial);
   assign quot_next = {quot_ff[albr_pkg::BLK_W-2:0], fits};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= albr_pkg::F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      lsec_ff  <= lsec_in;
      count_ff <= count_in;
      bound_ff <= bound_in;
      rem_ff   <= rem_in;
      low_ff   <= low_in;
      quot_ff  <= quot_in;
      cnt_ff   <= cnt_in;
      cmd_ff   <= cmd_in;
   end

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      lsec_in  = lsec_ff;
      count_in = count_ff;
      bound_in = bound_ff;
      rem_in   = rem_ff;
      low_in   = low_ff;
      quot_in  = quot_ff;
      cnt_in   = cnt_ff;
      cmd_in   = cmd_ff;
      unique case (state_ff)
         albr_pkg::F_IDLE: begin
            if (accept) begin
               op_in    = albr_pkg::op_type'(req_operation);
               lsec_in  = req_logical_sector;
               count_in = req_sector_count;
               state_in = albr_pkg::F_MUL;
            end
         end
         albr_pkg::F_MUL: begin
            // lsec / spb < lim  <=>  lsec < spb * lim
            bound_in = albr_pkg::BOUND_W'(spb) * albr_pkg::BOUND_W'(lim);
            state_in = albr_pkg::F_RANGE;
         end
         albr_pkg::F_RANGE: begin
            cmd_in.blk = '0;
            state_in   = albr_pkg::F_PUSH;
            if (op_ff == albr_pkg::OP_FLUSH) begin
               cmd_in.kind = albr_pkg::CMD_FLUSH;
            end else if (op_ff == albr_pkg::OP_OTHER || spb == '0 ||
                         count_ff != albr_pkg::COUNT_W'(spb) ||
                         lsec_ff >= albr_pkg::SECTOR_W'(bound_ff)) begin
               cmd_in.kind = albr_pkg::CMD_INVALID;
            end else begin
               // in range, so the top bits already sit below spb
               rem_in   = lsec_ff[albr_pkg::BLK_W +: albr_pkg::SPB_W];
               low_in   = lsec_ff[albr_pkg::BLK_W-1:0];
               quot_in  = '0;
               cnt_in   = '0;
               state_in = albr_pkg::F_DIV;
            end
         end
         albr_pkg::F_DIV: begin
            rem_in  = rem_next;
            low_in  = low_ff << 1;
            quot_in = quot_next;
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == albr_pkg::DIV_CNT_W'(albr_pkg::BLK_W - 1)) begin
               cmd_in.blk = quot_next;
               if (rem_next != '0) begin
                  cmd_in.kind = albr_pkg::CMD_INVALID;
               end else if (op_ff == albr_pkg::OP_WRITE) begin
                  cmd_in.kind = albr_pkg::CMD_WRITE;
               end else begin
                  cmd_in.kind = albr_pkg::CMD_READ;
               end
               state_in = albr_pkg::F_PUSH;
            end
         end
         albr_pkg::F_PUSH: begin
            if (cmd_ready) begin
               state_in = albr_pkg::F_IDLE;
            end
         end
         default: begin
            state_in = albr_pkg::F_IDLE;
         end
      endcase
   end

   a_rem_below_spb: assert property (@(posedge clock) disable iff (reset)
      (state_ff == albr_pkg::F_DIV) |-> (rem_ff < spb))
      else $error("divider remainder not below block size");

   a_push_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == albr_pkg::F_PUSH && !cmd_ready) |=>
         (state_ff == albr_pkg::F_PUSH && $stable(cmd_ff)))
      else $error("command dropped while queue full");

   a_flush_fast: assert property (@(posedge clock) disable iff (reset)
      (state_ff == albr_pkg::F_RANGE && op_ff == albr_pkg::OP_FLUSH) |=>
         (state_ff == albr_pkg::F_PUSH && cmd_ff.kind == albr_pkg::CMD_FLUSH))
      else $error("flush not passed straight to queue");

endmodule

// ===== hw/rtl/albr_back.sv =====
// ----------------------------------------------------------------------------
// albr_back
// Map back end: clears the block map after reset, then executes queued reads
// and writes against the map and the append pointer, and holds the result.
// ----------------------------------------------------------------------------
module albr_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            cmd_valid,
   input  albr_pkg::cmd_type               cmd,
   output logic                            cmd_pop,
   input  logic [albr_pkg::SPB_W-1:0]      spb,
   input  logic [albr_pkg::SECTOR_W-1:0]   limit,
   output logic                            clear_done,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [albr_pkg::STATUS_W-1:0]   rsp_status,
   output logic [albr_pkg::SECTOR_W-1:0]   rsp_phys_sector
);

   albr_pkg::back_state_type       state_ff, state_in;
   logic [albr_pkg::BLK_W-1:0]     clr_idx_ff, clr_idx_in;
   logic [albr_pkg::SECTOR_W-1:0]  ap_ff, ap_in;
   logic [albr_pkg::BLK_W-1:0]     blk_ff, blk_in;
   albr_pkg::status_type           res_status_ff, res_status_in;
   logic [albr_pkg::SECTOR_W-1:0]  res_psec_ff, res_psec_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   albr_pkg::status_type           rsp_status_ff, rsp_status_in;
   logic [albr_pkg::SECTOR_W-1:0]  rsp_psec_ff, rsp_psec_in;
   logic                           ram_we;
   logic [albr_pkg::BLK_W-1:0]     ram_waddr;
   logic [albr_pkg::MAP_W-1:0]     ram_wdata;
   logic [albr_pkg::MAP_W-1:0]     ram_rdata;
   logic [albr_pkg::SECTOR_W:0]    end_sum;
   logic                           no_space;
   logic                           out_free;

   albr_ram #(
      .WIDTH (albr_pkg::MAP_W),
      .DEPTH (albr_pkg::MAP_ENTRIES)
   ) u_map (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (cmd.blk),
      .rdata (ram_rdata)
   );

   assign end_sum  = {1'b0, ap_ff} + (albr_pkg::SECTOR_W+1)'(spb);
   assign no_space = end_sum > {1'b0, limit};
   assign out_free = !rsp_valid_ff || rsp_ready;

   assign clear_done      = state_ff != albr_pkg::B_CLEAR;
   assign cmd_pop         = (state_ff == albr_pkg::B_IDLE) && cmd_valid;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_phys_sector = rsp_psec_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= albr_pkg::B_CLEAR;
         clr_idx_ff   <= '0;
         ap_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         ap_ff        <= ap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      blk_ff        <= blk_in;
      res_status_ff <= res_status_in;
      res_psec_ff   <= res_psec_in;
      rsp_status_ff <= rsp_status_in;
      rsp_psec_ff   <= rsp_psec_in;
   end

   always_comb begin
      state_in      = state_ff;
      clr_idx_in    = clr_idx_ff;
      ap_in         = ap_ff;
      blk_in        = blk_ff;
      res_status_in = res_status_ff;
      res_psec_in   = res_psec_ff;
      rsp_status_in = rsp_status_ff;
      rsp_psec_in   = rsp_psec_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      ram_we        = 1'b0;
      ram_waddr     = blk_ff;
      ram_wdata     = {1'b1, ap_ff};
      unique case (state_ff)
         albr_pkg::B_CLEAR: begin
            ram_we     = 1'b1;
            ram_waddr  = clr_idx_ff;
            ram_wdata  = '0;
            clr_idx_in = clr_idx_ff + 1'b1;
            if (clr_idx_ff == '1) begin
               state_in = albr_pkg::B_IDLE;
            end
         end
         albr_pkg::B_IDLE: begin
            if (cmd_valid) begin
               blk_in      = cmd.blk;
               res_psec_in = '0;
               case (cmd.kind)
                  albr_pkg::CMD_READ:  state_in = albr_pkg::B_READ;
                  albr_pkg::CMD_WRITE: state_in = albr_pkg::B_WRITE;
                  albr_pkg::CMD_FLUSH: begin
                     res_status_in = albr_pkg::ST_FLUSH;
                     state_in      = albr_pkg::B_OUT;
                  end
                  default: begin
                     res_status_in = albr_pkg::ST_INVALID;
                     state_in      = albr_pkg::B_OUT;
                  end
               endcase
            end
         end
         albr_pkg::B_READ: begin
            // map entry was addressed at the pop
            if (ram_rdata[albr_pkg::MAP_W-1]) begin
               res_status_in = albr_pkg::ST_REMAPPED;
               res_psec_in   = ram_rdata[albr_pkg::SECTOR_W-1:0];
            end else begin
               res_status_in = albr_pkg::ST_UNMAPPED;
            end
            state_in = albr_pkg::B_OUT;
         end
         albr_pkg::B_WRITE: begin
            if (no_space) begin
               res_status_in = albr_pkg::ST_NOSPACE;
            end else begin
               res_status_in = albr_pkg::ST_REMAPPED;
               res_psec_in   = ap_ff;
               ram_we        = 1'b1;
               ap_in         = end_sum[albr_pkg::SECTOR_W-1:0];
            end
            state_in = albr_pkg::B_OUT;
         end
         albr_pkg::B_OUT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_psec_in   = res_psec_ff;
               state_in      = albr_pkg::B_IDLE;
            end
         end
         default: begin
            state_in = albr_pkg::B_IDLE;
         end
      endcase
   end

   a_ap_advance: assert property (@(posedge clock) disable iff (reset)
      (state_ff == albr_pkg::B_WRITE && !no_space) |=>
         (ap_ff == $past(end_sum[albr_pkg::SECTOR_W-1:0])))
      else $error("append pointer not advanced by one block");

   a_ap_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff != albr_pkg::B_WRITE) |=> $stable(ap_ff))
      else $error("append pointer moved outside a write");

   a_no_pop_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == albr_pkg::B_CLEAR) |-> !cmd_pop)
      else $error("command popped during map clear");

   a_psec_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != albr_pkg::ST_REMAPPED) |-> (rsp_psec_ff == '0))
      else $error("nonzero sector on a non-remapped result");

endmodule

// ===== hw/rtl/append_log_block_remapper.sv =====
// ----------------------------------------------------------------------------
// append_log_block_remapper
// Maps block-aligned read/write requests onto an append-only physical log.
// ----------------------------------------------------------------------------
// Use:
//   req_*  : request channel (operation, logical sector, sector count),
//            valid/ready; one transfer per request.
//   rsp_*  : result channel (status, physical sector), valid/ready; exactly
//            one transfer per request, in request order.
//   csr_*  : register writes (block size, logical block count, physical
//            limit); user rule: only while the block is idle, unenforced.
// Path: a read or write passes the front end (block size product, range
//   check, 12-step bit-serial divide, queue push), then the back end (pop,
//   map access, output register). Flush and requests rejected at the range
//   check skip the divide; flush and invalid commands skip the map access.
// Overlap: the front end takes a new request only after it has pushed the
//   last command, so the serial divider paces reads and writes; the back
//   end works through the queued commands meanwhile.
// Reset: all 4096 map entries are swept to unmapped, one entry a cycle;
//   req_ready stays low until the sweep ends. Registers return to defaults.
// Stall: a result waits in the output register; a two-entry command queue
//   lets the front end keep taking requests while the receiver stalls.
// ----------------------------------------------------------------------------
module append_log_block_remapper (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [albr_pkg::OP_W-1:0]         req_operation,
   input  logic [albr_pkg::SECTOR_W-1:0]     req_logical_sector,
   input  logic [albr_pkg::COUNT_W-1:0]      req_sector_count,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [albr_pkg::STATUS_W-1:0]     rsp_status,
   output logic [albr_pkg::SECTOR_W-1:0]     rsp_phys_sector,
   input  logic                              csr_we,
   input  logic [albr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [albr_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   logic [albr_pkg::SPB_W-1:0]    spb_ff, spb_in;
   logic [albr_pkg::LBC_W-1:0]    lbc_ff, lbc_in;
   logic [albr_pkg::SECTOR_W-1:0] limit_ff, limit_in;
   logic                          clear_done;
   logic                          push, push_ready;
   albr_pkg::cmd_type             push_cmd;
   logic                          pop, pop_valid;
   albr_pkg::cmd_type             pop_cmd;

   always_comb begin
      spb_in   = spb_ff;
      lbc_in   = lbc_ff;
      limit_in = limit_ff;
      if (csr_we) begin
         unique case (csr_index)
            albr_pkg::CSR_SECTORS_PER_BLOCK:
               spb_in = csr_wdata[albr_pkg::SPB_W-1:0];
            albr_pkg::CSR_LOGICAL_BLOCK_COUNT:
               lbc_in = csr_wdata[albr_pkg::LBC_W-1:0];
            albr_pkg::CSR_PHYS_LIMIT:
               limit_in = csr_wdata[albr_pkg::SECTOR_W-1:0];
            default: begin
               spb_in = spb_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         spb_ff   <= albr_pkg::SPB_RESET;
         lbc_ff   <= albr_pkg::LBC_RESET;
         limit_ff <= albr_pkg::LIMIT_RESET;
      end else begin
         spb_ff   <= spb_in;
         lbc_ff   <= lbc_in;
         limit_ff <= limit_in;
      end
   end

   albr_front u_front (
      .clock              (clock),
      .reset              (reset),
      .enable             (clear_done),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_operation      (req_operation),
      .req_logical_sector (req_logical_sector),
      .req_sector_count   (req_sector_count),
      .spb                (spb_ff),
      .lbc                (lbc_ff),
      .cmd_valid          (push),
      .cmd_ready          (push_ready),
      .cmd                (push_cmd)
   );

   albr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .push_ready (push_ready),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_cmd    (pop_cmd)
   );

   albr_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cmd_valid       (pop_valid),
      .cmd             (pop_cmd),
      .cmd_pop         (pop),
      .spb             (spb_ff),
      .limit           (limit_ff),
      .clear_done      (clear_done),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_phys_sector (rsp_phys_sector)
   );

endmodule
